[rtl/core/lbbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbbc_pkg: shared types and constants
// Field widths, opcode and status codes, and the front-to-back command record.
// ----------------------------------------------------------------------------
package lbbc_pkg;

    localparam int KEY_W    = 32;
    localparam int BYTES_W  = 20;
    localparam int HANDLE_W = 32;
    localparam int TOTAL_W  = 24;
    localparam int USE_W    = 25;
    localparam int EVICT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 24;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic       OP_LOOKUP = 1'b0;
    localparam logic       OP_INSERT = 1'b1;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic       CFG_MAX_TOTAL = 1'b0;
    localparam logic       CFG_MAX_ITEM  = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic                reject;
        logic [KEY_W-1:0]    key;
        logic [BYTES_W-1:0]  item_bytes;
        logic [HANDLE_W-1:0] data_handle;
    } cmd_t;

endpackage

[rtl/core/lbbc_if.sv]
// ----------------------------------------------------------------------------
// lbbc_in_if / lbbc_out_if: valid-ready channels
// Request and response channels of the cache.
// ----------------------------------------------------------------------------
interface lbbc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [lbbc_pkg::KEY_W-1:0]      key;
    logic [lbbc_pkg::BYTES_W-1:0]    item_bytes;
    logic [lbbc_pkg::HANDLE_W-1:0]   data_handle;
    modport source (output valid, opcode, key, item_bytes, data_handle, input ready);
    modport sink   (input valid, opcode, key, item_bytes, data_handle, output ready);
endinterface

interface lbbc_out_if;
    logic                            valid;
    logic                            ready;
    logic [lbbc_pkg::STATUS_W-1:0]   status;
    logic [lbbc_pkg::BYTES_W-1:0]    found_bytes;
    logic [lbbc_pkg::HANDLE_W-1:0]   found_handle;
    logic [lbbc_pkg::EVICT_W-1:0]    evicted_count;
    modport source (output valid, status, found_bytes, found_handle, evicted_count,
                    input ready);
    modport sink   (input valid, status, found_bytes, found_handle, evicted_count,
                    output ready);
endinterface

[rtl/core/lru_byte_budget_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_unit: LRU cache with byte budget
// Keyed LRU table of handles; inserts evict least-recent entries to budget.
//
//   channel | dir | transaction
//   req     | in  | opcode, key, item_bytes, data_handle
//   rsp     | out | status, found_bytes, found_handle, evicted_count
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Lookup and reject: the response is registered in the match state after acceptance.
// Insert: match, then evictions for budget (at most ENTRIES), one per
// cycle through the shared least-recent search, then a full-table eviction, then store.
// Reset empties the table at once. A two-deep queue holds requests while
// the sequencer or a stalled response is busy.
// ----------------------------------------------------------------------------
module lru_byte_budget_cache_unit #(
    parameter int ENTRIES = lbbc_pkg::ENTRIES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [lbbc_pkg::CFG_W-1:0]  cfg_data,
    lbbc_in_if.sink                     req,
    lbbc_out_if.source                  rsp
);
    import lbbc_pkg::*;

    logic [TOTAL_W-1:0] max_total_reg;
    logic [BYTES_W-1:0] max_item_reg;
    logic               cmd_valid, cmd_ready;
    cmd_t               cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= '1;
            max_item_reg  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TOTAL: max_total_reg <= cfg_data;
                CFG_MAX_ITEM:  max_item_reg  <= cfg_data[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    lbbc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .size_cap       (max_item_reg),
        .req            (req),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    lbbc_back #(.ENTRIES(ENTRIES)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_total_bytes (max_total_reg),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd             (cmd),
        .rsp             (rsp)
    );

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("response dropped while stalled");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_HIT |-> rsp.found_bytes == '0 && rsp.found_handle == '0)
        else $error("nonzero payload on non-hit");
    a_evict_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_INSERTED |-> rsp.evicted_count == '0)
        else $error("evictions reported without insert");

endmodule

[rtl/core/lbbc_front.sv]
// ----------------------------------------------------------------------------
// lbbc_front: request intake and classification
// Accepts transactions, flags oversized inserts, and feeds a two-entry queue.
// ----------------------------------------------------------------------------
module lbbc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lbbc_pkg::BYTES_W-1:0]  size_cap,
    lbbc_in_if.sink                       req,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output lbbc_pkg::cmd_t                cmd
);
    import lbbc_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    cmd_t        in_cmd;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        in_cmd.opcode      = req.opcode;
        in_cmd.reject      = (req.opcode == OP_INSERT) && (req.item_bytes > size_cap);
        in_cmd.key         = req.key;
        in_cmd.item_bytes  = req.item_bytes;
        in_cmd.data_handle = req.data_handle;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

[rtl/core/lbbc_back.sv]
// ----------------------------------------------------------------------------
// lbbc_back: cache table and sequencer
// Parallel key match, then one eviction of the least-recent entry per cycle.
// ----------------------------------------------------------------------------
module lbbc_back #(
    parameter int ENTRIES = lbbc_pkg::ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lbbc_pkg::TOTAL_W-1:0]  max_total_bytes,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  lbbc_pkg::cmd_t                cmd,
    lbbc_out_if.source                    rsp
);
    import lbbc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_EVICT = 3'd2;
    localparam logic [2:0] S_FULL  = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;

    logic [2:0]           state_reg, state_next;
    cmd_t                 cur_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [KEY_W-1:0]     key_mem    [ENTRIES];
    logic [BYTES_W-1:0]   bytes_mem  [ENTRIES];
    logic [HANDLE_W-1:0]  handle_mem [ENTRIES];
    logic [IDX_W-1:0]     rank_mem   [ENTRIES];
    logic [USE_W-1:0]     use_reg;
    logic [EVICT_W-1:0]   evict_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [BYTES_W-1:0]   out_bytes_reg;
    logic [HANDLE_W-1:0]  out_handle_reg;
    logic [EVICT_W-1:0]   out_evict_reg;

    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 any_valid, any_free;
    logic [IDX_W-1:0]     old_idx, free_idx;
    logic [IDX_W-1:0]     last_rank;
    logic [USE_W-1:0]     use_add;
    logic                 over;

    // valid ranks always form 0..n-1, so the least-recent entry holds rank n-1
    always_comb
    begin
        hit = 1'b0; hit_idx = '0;
        any_free = 1'b0; free_idx = '0;
        old_idx = '0;
        any_valid = |valid_reg;
        last_rank = IDX_W'($countones(valid_reg) - 1);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && key_mem[i] == cur_reg.key)
            begin
                hit = 1'b1; hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1; free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && rank_mem[i] == last_rank)
                old_idx = IDX_W'(i);
        end
        use_add = use_reg + USE_W'(cur_reg.item_bytes);
        over    = use_reg > USE_W'(max_total_bytes);
    end

    assign cmd_ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found_bytes   = out_bytes_reg;
    assign rsp.found_handle  = out_handle_reg;
    assign rsp.evicted_count = out_evict_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (cmd_valid && cmd_ready) state_next = S_MATCH;
            S_MATCH:
                if (cur_reg.opcode == OP_LOOKUP || cur_reg.reject) state_next = S_IDLE;
                else state_next = S_EVICT;
            S_EVICT: if (!over || !any_valid) state_next = S_FULL;
            S_FULL:  state_next = S_STORE;
            S_STORE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            use_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_MATCH:
                begin
                    if (cur_reg.opcode == OP_LOOKUP || cur_reg.reject)
                        out_valid_reg <= 1'b1;
                    else if (hit)
                    begin
                        valid_reg[hit_idx] <= 1'b0;
                        use_reg <= use_add - USE_W'(bytes_mem[hit_idx]);
                    end
                    else
                        use_reg <= use_add;
                end
                S_EVICT:
                    if (over && any_valid)
                    begin
                        valid_reg[old_idx] <= 1'b0;
                        use_reg <= use_reg - USE_W'(bytes_mem[old_idx]);
                    end
                S_FULL:
                    if (!any_free)
                    begin
                        valid_reg[old_idx] <= 1'b0;
                        use_reg <= use_reg - USE_W'(bytes_mem[old_idx]);
                    end
                S_STORE:
                begin
                    valid_reg[free_idx] <= 1'b1;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ranks are compacted when a hit is removed and evictions take the top rank, so valid entries hold 0..n-1
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd_ready)
        begin
            cur_reg   <= cmd;
            evict_reg <= '0;
        end
        unique case (state_reg)
            S_MATCH:
            begin
                out_bytes_reg  <= '0;
                out_handle_reg <= '0;
                out_evict_reg  <= '0;
                if (cur_reg.opcode == OP_LOOKUP)
                begin
                    out_status_reg <= hit ? ST_HIT : ST_MISS;
                    if (hit)
                    begin
                        out_bytes_reg  <= bytes_mem[hit_idx];
                        out_handle_reg <= handle_mem[hit_idx];
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && rank_mem[i] < rank_mem[hit_idx])
                                rank_mem[i] <= rank_mem[i] + 1'b1;
                        rank_mem[hit_idx] <= '0;
                    end
                end
                else if (cur_reg.reject)
                    out_status_reg <= ST_REJECTED;
                else if (hit)
                    for (int i = 0; i < ENTRIES; i++)
                        if (valid_reg[i] && rank_mem[i] > rank_mem[hit_idx])
                            rank_mem[i] <= rank_mem[i] - 1'b1;
            end
            S_EVICT:
                if (over && any_valid)
                begin
                    if (evict_reg != '1)
                        evict_reg <= evict_reg + 1'b1;
                end
            S_FULL:
                if (!any_free && evict_reg != '1)
                    evict_reg <= evict_reg + 1'b1;
            S_STORE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (valid_reg[i])
                        rank_mem[i] <= rank_mem[i] + 1'b1;
                key_mem[free_idx]    <= cur_reg.key;
                bytes_mem[free_idx]  <= cur_reg.item_bytes;
                handle_mem[free_idx] <= cur_reg.data_handle;
                rank_mem[free_idx]   <= '0;
                out_status_reg       <= ST_INSERTED;
                out_evict_reg        <= evict_reg;
            end
            default: ;
        endcase
    end

endmodule
